[sv/sbm_pkg.sv]
// Shared types, register codes, limits and the PWM curve ROM for the supply/bulb monitor.
package sbm_pkg;

	// Field widths
	localparam int LEVEL_W = 10;
	localparam int LIGHT_W = 8;
	localparam int DUTY_W  = 8;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 3;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [LIGHT_W-1:0] light_t;
	typedef logic [DUTY_W-1:0]  duty_t;
	typedef logic [OP_W-1:0]    op_t;
	typedef logic [STAT_W-1:0]  stat_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Sample source codes
	localparam op_t OP_BULB  = 2'd0;
	localparam op_t OP_BATT  = 2'd1;
	localparam op_t OP_LIGHT = 2'd2;

	// Battery classes
	localparam stat_t BATT_UNKNOWN  = 2'd0;
	localparam stat_t BATT_CRANKING = 2'd1;
	localparam stat_t BATT_NORMAL   = 2'd2;
	localparam stat_t BATT_CHARGING = 2'd3;

	// Bulb classes
	localparam stat_t BULB_ZERO    = 2'd0;
	localparam stat_t BULB_LOADED  = 2'd1;
	localparam stat_t BULB_FULL    = 2'd2;
	localparam stat_t BULB_UNKNOWN = 2'd3;

	// Limit register indexes
	localparam cfg_idx_t REG_BATT_LOW    = 3'd0;
	localparam cfg_idx_t REG_BATT_CRANK  = 3'd1;
	localparam cfg_idx_t REG_BATT_CHARGE = 3'd2;
	localparam cfg_idx_t REG_BATT_OVER   = 3'd3;
	localparam cfg_idx_t REG_BULB_ZERO   = 3'd4;
	localparam cfg_idx_t REG_BULB_LOAD   = 3'd5;
	localparam cfg_idx_t REG_BULB_FULL   = 3'd6;

	// Limit reset values
	localparam level_t RST_BATT_LOW    = 10'd417;
	localparam level_t RST_BATT_CRANK  = 10'd730;
	localparam level_t RST_BATT_CHARGE = 10'd904;
	localparam level_t RST_BATT_OVER   = 10'd1023;
	localparam level_t RST_BULB_ZERO   = 10'd2;
	localparam level_t RST_BULB_LOAD   = 10'd209;
	localparam level_t RST_BULB_FULL   = 10'd695;

	typedef struct packed {
		level_t batt_low;
		level_t batt_crank;
		level_t batt_charge;
		level_t batt_over;
		level_t bulb_zero;
		level_t bulb_load;
		level_t bulb_full;
	} cfg_t;

	// PWM curve table
	localparam int TABLE_DEPTH = 120;
	localparam int TABLE_BASE  = 904;
	localparam int TBL_IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ROM_FILLED  = 120;
	localparam int ROM_IDX_W   = $clog2(ROM_FILLED);

	localparam duty_t PWM_OVER = 8'd198;
	localparam duty_t PWM_FULL = 8'd255;
	localparam duty_t PWM_PAD  = 8'd198;

	localparam duty_t ROM_CURVE [ROM_FILLED] = '{
		8'd254, 8'd254, 8'd253, 8'd253, 8'd252, 8'd252, 8'd251, 8'd251,
		8'd250, 8'd250, 8'd249, 8'd249, 8'd248, 8'd248, 8'd247, 8'd246,
		8'd246, 8'd245, 8'd244, 8'd243, 8'd243, 8'd242, 8'd242, 8'd242,
		8'd242, 8'd241, 8'd241, 8'd241, 8'd240, 8'd240, 8'd239, 8'd239,
		8'd238, 8'd238, 8'd237, 8'd237, 8'd236, 8'd235, 8'd234, 8'd234,
		8'd233, 8'd233, 8'd232, 8'd232, 8'd231, 8'd231, 8'd230, 8'd230,
		8'd230, 8'd229, 8'd229, 8'd228, 8'd228, 8'd227, 8'd227, 8'd227,
		8'd226, 8'd226, 8'd225, 8'd225, 8'd224, 8'd223, 8'd223, 8'd222,
		8'd222, 8'd221, 8'd221, 8'd220, 8'd220, 8'd219, 8'd219, 8'd219,
		8'd219, 8'd218, 8'd218, 8'd218, 8'd217, 8'd217, 8'd216, 8'd216,
		8'd215, 8'd215, 8'd214, 8'd214, 8'd213, 8'd213, 8'd212, 8'd212,
		8'd211, 8'd211, 8'd210, 8'd210, 8'd210, 8'd210, 8'd209, 8'd209,
		8'd209, 8'd208, 8'd208, 8'd207, 8'd207, 8'd206, 8'd206, 8'd206,
		8'd205, 8'd205, 8'd204, 8'd204, 8'd203, 8'd203, 8'd202, 8'd202,
		8'd201, 8'd201, 8'd200, 8'd200, 8'd200, 8'd199, 8'd199, 8'd199
	};

	// Curve lookup; entries past the filled part read as the pad value
	function automatic duty_t rom_read(input logic [TBL_IDX_W-1:0] idx);
		logic [ROM_IDX_W-1:0] ridx;
		ridx = ROM_IDX_W'(idx);
		if (32'(idx) < ROM_FILLED)
			return ROM_CURVE[ridx];
		return PWM_PAD;
	endfunction

	// Running average; an empty (zero) store takes the new reading as is
	function automatic level_t blend(input level_t stored, input level_t fresh);
		logic [LEVEL_W:0] sum;
		sum = {1'b0, stored} + {1'b0, fresh};
		if (stored == '0)
			return fresh;
		return sum[LEVEL_W:1];
	endfunction

endpackage

[sv/sbm_ifs.sv]
// Channel interfaces: sample input, result output and limit register writes.
interface sbm_sample_if import sbm_pkg::*; ();
	logic   valid;
	logic   ready;
	op_t    operation;
	level_t sample_value;

	modport source (output valid, output operation, output sample_value, input ready);
	modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

interface sbm_result_if import sbm_pkg::*; ();
	logic   valid;
	logic   ready;
	stat_t  batt_status;
	stat_t  bulb_status;
	logic   pwm_valid;
	duty_t  pwm_value;
	level_t batt_level;
	level_t bulb_level;
	light_t light_level;

	modport source (output valid, output batt_status, output bulb_status, output pwm_valid,
		output pwm_value, output batt_level, output bulb_level, output light_level,
		input ready);
	modport sink (input valid, input batt_status, input bulb_status, input pwm_valid,
		input pwm_value, input batt_level, input bulb_level, input light_level,
		output ready);
endinterface

interface sbm_cfg_if import sbm_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	level_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/sbm_cfg_regs.sv]
// Limit register file written through the configuration channel.
module sbm_cfg_regs import sbm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sbm_cfg_if.sink cfg,
	output cfg_t    lim
);

	cfg_t lim_q;

	// Writes are always taken; indexes past the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.batt_low    <= RST_BATT_LOW;
			lim_q.batt_crank  <= RST_BATT_CRANK;
			lim_q.batt_charge <= RST_BATT_CHARGE;
			lim_q.batt_over   <= RST_BATT_OVER;
			lim_q.bulb_zero   <= RST_BULB_ZERO;
			lim_q.bulb_load   <= RST_BULB_LOAD;
			lim_q.bulb_full   <= RST_BULB_FULL;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BATT_LOW:    lim_q.batt_low    <= cfg.data;
				REG_BATT_CRANK:  lim_q.batt_crank  <= cfg.data;
				REG_BATT_CHARGE: lim_q.batt_charge <= cfg.data;
				REG_BATT_OVER:   lim_q.batt_over   <= cfg.data;
				REG_BULB_ZERO:   lim_q.bulb_zero   <= cfg.data;
				REG_BULB_LOAD:   lim_q.bulb_load   <= cfg.data;
				REG_BULB_FULL:   lim_q.bulb_full   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign lim = lim_q;

endmodule

[sv/sbm_classify.sv]
// Battery and bulb level classification against the limit registers.
module sbm_classify import sbm_pkg::*; (
	input  cfg_t   lim,
	input  level_t batt,
	input  level_t bulb,
	output stat_t  batt_status,
	output stat_t  bulb_status
);

	// Battery: ascending thresholds
	always_comb begin
		if (batt < lim.batt_low)
			batt_status = BATT_UNKNOWN;
		else if (batt < lim.batt_crank)
			batt_status = BATT_CRANKING;
		else if (batt < lim.batt_charge)
			batt_status = BATT_NORMAL;
		else
			batt_status = BATT_CHARGING;
	end

	// Bulb: zero, loaded, full, otherwise in between
	always_comb begin
		if (bulb <= lim.bulb_zero)
			bulb_status = BULB_ZERO;
		else if (bulb < lim.bulb_load)
			bulb_status = BULB_LOADED;
		else if (bulb > lim.bulb_full)
			bulb_status = BULB_FULL;
		else
			bulb_status = BULB_UNKNOWN;
	end

endmodule

[sv/sbm_pwm_lut.sv]
// Target PWM duty from the battery level: fixed ranges plus curve ROM lookup.
module sbm_pwm_lut import sbm_pkg::*; (
	input  cfg_t   lim,
	input  level_t batt,
	output logic   pwm_valid,
	output duty_t  pwm_value
);

	level_t                 offs;
	logic                   in_table;
	logic [TBL_IDX_W-1:0]   idx;
	duty_t                  rom_q;

	// Offset into the curve; only meaningful at or above the table base
	assign offs     = batt - LEVEL_W'(TABLE_BASE);
	assign in_table = ({1'b0, offs} < (LEVEL_W+1)'(TABLE_DEPTH));
	assign idx      = offs[TBL_IDX_W-1:0];
	assign rom_q    = rom_read(idx);

	always_comb begin
		pwm_valid = 1'b1;
		pwm_value = '0;
		if (batt < lim.batt_low) begin
			pwm_valid = 1'b0;
		end else if (batt > lim.batt_over) begin
			pwm_value = PWM_OVER;
		end else if (batt < LEVEL_W'(TABLE_BASE)) begin
			pwm_value = PWM_FULL;
		end else if (in_table) begin
			pwm_value = rom_q;
		end else begin
			pwm_valid = 1'b0;
		end
	end

endmodule

[sv/supply_bulb_monitor_pwm_target_top.sv]
// Supply/bulb monitor top: input register, level update, classify, PWM target, result register.
// Timing: the input register holds a sample until the result register is free or being drained,
// then the result register loads it; a stalled result register holds the result until taken.
// Throughput: one sample per cycle while results are taken; the level update into the averaging
// registers is combinational. A stalled result holds the input register, which then holds ready.
// Reset: levels and light reading cleared, limits at defaults, both stages empty.
module supply_bulb_monitor_pwm_target_top import sbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sbm_sample_if.sink  sample,
	sbm_result_if.source result,
	sbm_cfg_if.sink     cfg
);

	cfg_t   lim;
	logic   valid_s1;
	op_t    op_s1;
	level_t samp_s1;
	logic   adv_s1;
	level_t batt_q, bulb_q;
	light_t light_q;
	level_t batt_nx, bulb_nx;
	light_t light_nx;
	stat_t  batt_stat, bulb_stat;
	logic   pwm_ok;
	duty_t  pwm_duty;
	logic   out_valid_q;
	stat_t  batt_stat_q, bulb_stat_q;
	logic   pwm_ok_q;
	duty_t  pwm_duty_q;

	sbm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.lim    (lim)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign adv_s1       = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (sample.ready)
			valid_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			op_s1   <= sample.operation;
			samp_s1 <= sample.sample_value;
		end
	end

	// Level update; the unused source code leaves everything alone
	always_comb begin
		batt_nx  = batt_q;
		bulb_nx  = bulb_q;
		light_nx = light_q;
		case (op_s1)
			OP_BULB:  bulb_nx  = blend(bulb_q, samp_s1);
			OP_BATT:  batt_nx  = blend(batt_q, samp_s1);
			OP_LIGHT: light_nx = samp_s1[LIGHT_W-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batt_q  <= '0;
			bulb_q  <= '0;
			light_q <= '0;
		end else if (adv_s1) begin
			batt_q  <= batt_nx;
			bulb_q  <= bulb_nx;
			light_q <= light_nx;
		end
	end

	sbm_classify u_class (
		.lim         (lim),
		.batt        (batt_nx),
		.bulb        (bulb_nx),
		.batt_status (batt_stat),
		.bulb_status (bulb_stat)
	);

	sbm_pwm_lut u_pwm (
		.lim       (lim),
		.batt      (batt_nx),
		.pwm_valid (pwm_ok),
		.pwm_value (pwm_duty)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv_s1)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			batt_stat_q <= batt_stat;
			bulb_stat_q <= bulb_stat;
			pwm_ok_q    <= pwm_ok;
			pwm_duty_q  <= pwm_duty;
		end
	end

	// Levels in the result are the stored levels after the item's update
	assign result.valid       = out_valid_q;
	assign result.batt_status = batt_stat_q;
	assign result.bulb_status = bulb_stat_q;
	assign result.pwm_valid   = pwm_ok_q;
	assign result.pwm_value   = pwm_duty_q;
	assign result.batt_level  = batt_q;
	assign result.bulb_level  = bulb_q;
	assign result.light_level = light_q;

	// No duty byte without a valid target
	a_pwm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.pwm_valid || result.pwm_value == '0))
		else $error("pwm_value nonzero while pwm_valid low");

	// Unknown battery class and a PWM target exclude each other
	a_batt_pwm: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.batt_status == BATT_UNKNOWN) |-> !result.pwm_valid)
		else $error("pwm target given for unknown battery class");

	// Stored levels change only when an item moves through stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> ($stable(batt_q) && $stable(bulb_q) && $stable(light_q)))
		else $error("level state changed without an item");

	// An accepted sample always lands in stage 1
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> valid_s1)
		else $error("accepted sample lost at stage 1");

endmodule

[bench/sbm_checker.sv]
// Scoreboard for the supply/bulb monitor: predicts each result from accepted samples and compares.
module sbm_checker import sbm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	sbm_sample_if smp,
	sbm_result_if res,
	sbm_cfg_if    regs,
	output int    outstanding,
	output int    errors
);

	// One predicted monitor reading
	typedef struct packed {
		stat_t  batt_status;
		stat_t  bulb_status;
		logic   pwm_valid;
		duty_t  pwm_value;
		level_t batt_level;
		level_t bulb_level;
		light_t light_level;
	} reading_t;

	// Shadow copy of limits and levels
	cfg_t     lim;
	level_t   batt_avg;
	level_t   bulb_avg;
	light_t   light_val;
	reading_t readings_due[$];

	// Running mean; an empty store takes the fresh reading
	function automatic level_t mean_level(input level_t held, input level_t fresh);
		int total;
		total = int'(held) + int'(fresh);
		if (held == '0)
			return fresh;
		return level_t'(total / 2);
	endfunction

	// Apply one sample to the shadow levels and derive the reading it produces
	function automatic reading_t predict_reading(input op_t op, input level_t val);
		reading_t r;
		int idx;
		case (op)
			OP_BULB:  bulb_avg = mean_level(bulb_avg, val);
			OP_BATT:  batt_avg = mean_level(batt_avg, val);
			OP_LIGHT: light_val = val[LIGHT_W-1:0];
			default: ;
		endcase

		// battery class
		if (batt_avg < lim.batt_low)
			r.batt_status = BATT_UNKNOWN;
		else if (batt_avg < lim.batt_crank)
			r.batt_status = BATT_CRANKING;
		else if (batt_avg < lim.batt_charge)
			r.batt_status = BATT_NORMAL;
		else
			r.batt_status = BATT_CHARGING;

		// bulb class
		if (bulb_avg <= lim.bulb_zero)
			r.bulb_status = BULB_ZERO;
		else if (bulb_avg < lim.bulb_load)
			r.bulb_status = BULB_LOADED;
		else if (bulb_avg > lim.bulb_full)
			r.bulb_status = BULB_FULL;
		else
			r.bulb_status = BULB_UNKNOWN;

		// pwm target from the updated battery level
		r.pwm_valid = 1'b1;
		r.pwm_value = '0;
		if (batt_avg < lim.batt_low) begin
			r.pwm_valid = 1'b0;
		end else if (batt_avg > lim.batt_over) begin
			r.pwm_value = PWM_OVER;
		end else if (int'(batt_avg) < TABLE_BASE) begin
			r.pwm_value = PWM_FULL;
		end else begin
			idx = int'(batt_avg) - TABLE_BASE;
			if (idx >= TABLE_DEPTH)
				r.pwm_valid = 1'b0;
			else if (idx < ROM_FILLED)
				r.pwm_value = ROM_CURVE[idx];
			else
				r.pwm_value = PWM_PAD;
		end

		r.batt_level = batt_avg;
		r.bulb_level = bulb_avg;
		r.light_level = light_val;
		return r;
	endfunction

	// Report and count one field mismatch
	task automatic check_field(input string field, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// Track register writes, sample transfers and result transfers
	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			lim = '{RST_BATT_LOW, RST_BATT_CRANK, RST_BATT_CHARGE, RST_BATT_OVER,
				RST_BULB_ZERO, RST_BULB_LOAD, RST_BULB_FULL};
			batt_avg = '0;
			bulb_avg = '0;
			light_val = '0;
			readings_due.delete();
			outstanding = 0;
		end else begin
			if (regs.valid && regs.ready) begin
				case (regs.index)
					REG_BATT_LOW:    lim.batt_low = regs.data;
					REG_BATT_CRANK:  lim.batt_crank = regs.data;
					REG_BATT_CHARGE: lim.batt_charge = regs.data;
					REG_BATT_OVER:   lim.batt_over = regs.data;
					REG_BULB_ZERO:   lim.bulb_zero = regs.data;
					REG_BULB_LOAD:   lim.bulb_load = regs.data;
					REG_BULB_FULL:   lim.bulb_full = regs.data;
					default: ;
				endcase
			end

			if (res.valid && res.ready) begin
				if (readings_due.size() == 0) begin
					$display("%0t: result transfer with nothing expected, batt_level %0d",
						$time, res.batt_level);
					errors++;
				end else begin
					want = readings_due.pop_front();
					check_field("batt_status", want.batt_status, res.batt_status);
					check_field("bulb_status", want.bulb_status, res.bulb_status);
					check_field("pwm_valid", want.pwm_valid, res.pwm_valid);
					check_field("pwm_value", want.pwm_value, res.pwm_value);
					check_field("batt_level", want.batt_level, res.batt_level);
					check_field("bulb_level", want.bulb_level, res.bulb_level);
					check_field("light_level", want.light_level, res.light_level);
				end
			end

			if (smp.valid && smp.ready)
				readings_due.push_back(predict_reading(smp.operation, smp.sample_value));

			outstanding = readings_due.size();
		end
	end

endmodule

[bench/supply_bulb_monitor_pwm_target_top_tb.sv]
// Testbench top for the supply/bulb monitor: clock, reset, stimulus, result stalls and verdict.
module supply_bulb_monitor_pwm_target_top_tb;
	import sbm_pkg::*;

	localparam op_t      OP_NONE      = 2'd3;
	localparam cfg_idx_t REG_UNUSED   = 3'd7;
	localparam int       STALL_CYCLES = 80;
	localparam int       CYCLE_LIMIT  = 200000;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle;
	int   recv_idle;
	int   long_stall_req;
	int   outstanding;
	int   mismatches;
	int   cycles;

	sbm_sample_if smp ();
	sbm_result_if res ();
	sbm_cfg_if    regs ();

	supply_bulb_monitor_pwm_target_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp),
		.result (res),
		.cfg    (regs)
	);

	sbm_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.smp         (smp),
		.res         (res),
		.regs        (regs),
		.outstanding (outstanding),
		.errors      (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		int stalls_done;
		stalls_done = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stalls_done != long_stall_req) begin
				stalls_done++;
				res.ready <= 1'b0;
				repeat (STALL_CYCLES - 1) @(negedge clk);
			end else begin
				res.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// One sample transfer, with random idle cycles ahead of it; starts and ends at a falling edge
	task automatic push_sample(input op_t op, input level_t val);
		while ($urandom_range(99) < send_idle) begin
			smp.valid <= 1'b0;
			@(negedge clk);
		end
		smp.valid <= 1'b1;
		smp.operation <= op;
		smp.sample_value <= val;
		@(posedge clk);
		while (!smp.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering samples and let every pending result come out
	task automatic settle();
		smp.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input cfg_idx_t idx, input level_t value);
		regs.valid <= 1'b1;
		regs.index <= idx;
		regs.data <= value;
		@(posedge clk);
		while (!regs.ready) @(posedge clk);
		@(negedge clk);
		regs.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic load_limits(input level_t batt_low, input level_t batt_crank,
		input level_t batt_charge, input level_t batt_over, input level_t bulb_zero,
		input level_t bulb_load, input level_t bulb_full);
		settle();
		write_limit(REG_BATT_LOW, batt_low);
		write_limit(REG_BATT_CRANK, batt_crank);
		write_limit(REG_BATT_CHARGE, batt_charge);
		write_limit(REG_BATT_OVER, batt_over);
		write_limit(REG_BULB_ZERO, bulb_zero);
		write_limit(REG_BULB_LOAD, bulb_load);
		write_limit(REG_BULB_FULL, bulb_full);
	endtask

	// Mostly runs of readings near one level so the averages settle there,
	// mixed with light samples, unused codes and fully random noise
	task automatic random_mix(input int count);
		int left;
		int run;
		int aim;
		int v;
		op_t target;
		left = count;
		while (left > 0) begin
			if ($urandom_range(9) < 2) begin
				push_sample(op_t'($urandom_range(3)), level_t'($urandom));
				left--;
			end else begin
				case ($urandom_range(4))
					0: aim = $urandom_range(12);
					1: aim = $urandom_range(520, 380);
					2: aim = $urandom_range(920, 680);
					3: aim = $urandom_range(1023, 880);
					default: aim = $urandom_range(1023);
				endcase
				target = ($urandom_range(9) < 7) ? OP_BATT : OP_BULB;
				run = $urandom_range(8, 2);
				while (run > 0 && left > 0) begin
					if ($urandom_range(7) == 0) begin
						push_sample(($urandom_range(1) != 0) ? OP_LIGHT : OP_NONE,
							level_t'($urandom));
					end else begin
						v = aim + int'($urandom_range(16)) - 8;
						if (v < 0)
							v = 0;
						if (v > 1023)
							v = 1023;
						push_sample(target, level_t'(v));
						run--;
					end
					left--;
				end
			end
		end
	endtask

	initial begin
		smp.valid = 1'b0;
		smp.operation = OP_BULB;
		smp.sample_value = '0;
		regs.valid = 1'b0;
		regs.index = REG_BATT_LOW;
		regs.data = '0;
		arst_n = 1'b0;
		send_idle = 23;
		recv_idle = 77;
		long_stall_req = 0;
		cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset limits: unused code on empty state
		push_sample(OP_NONE, 10'd0);
		push_sample(OP_NONE, 10'd1023);
		// empty bulb store takes the reading, then averaging
		push_sample(OP_BULB, 10'd0);
		push_sample(OP_BULB, 10'd1023);
		push_sample(OP_BULB, 10'd0);
		push_sample(OP_BULB, 10'd2);
		// ambient keeps the low byte only
		push_sample(OP_LIGHT, 10'd1023);
		push_sample(OP_LIGHT, 10'h100);
		push_sample(OP_LIGHT, 10'h0AA);
		// battery average falls back to zero, then takes the next reading whole
		push_sample(OP_BATT, 10'd1);
		push_sample(OP_BATT, 10'd0);
		push_sample(OP_BATT, 10'd1023);
		push_sample(OP_BATT, 10'd1023);
		// table start, just below it, the full-duty band and below the low limit
		push_sample(OP_BATT, 10'd785);
		push_sample(OP_BATT, 10'd902);
		push_sample(OP_BATT, 10'd0);
		push_sample(OP_BATT, 10'd0);
		push_sample(OP_BATT, 10'd1023);
		push_sample(OP_NONE, 10'h155);
		push_sample(OP_NONE, 10'h2AA);
		push_sample(OP_BULB, 10'd695);

		// Sender mostly busy, receiver mostly stalled, one long hold-off
		long_stall_req++;
		random_mix(300);

		// Sender mostly idle, receiver mostly ready; limits at the extremes
		send_idle = 77;
		recv_idle = 23;
		load_limits(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
		random_mix(40);
		load_limits(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
		random_mix(40);
		load_limits(level_t'($urandom), level_t'($urandom), level_t'($urandom),
			level_t'($urandom), level_t'($urandom), level_t'($urandom), level_t'($urandom));
		write_limit(REG_UNUSED, level_t'($urandom));
		random_mix(130);
		load_limits(level_t'($urandom_range(500, 300)), level_t'($urandom_range(800, 600)),
			level_t'($urandom_range(1000, 850)), level_t'($urandom_range(1023, 950)),
			level_t'($urandom_range(20)), level_t'($urandom_range(300, 100)),
			level_t'($urandom_range(900, 500)));
		random_mix(130);

		// No idling on either side, back at reset limits, another long hold-off
		send_idle = 0;
		recv_idle = 0;
		load_limits(RST_BATT_LOW, RST_BATT_CRANK, RST_BATT_CHARGE, RST_BATT_OVER,
			RST_BULB_ZERO, RST_BULB_LOAD, RST_BULB_FULL);
		long_stall_req++;
		random_mix(300);

		settle();
		repeat (6) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
